// ===== sv/rsfp_pkg.sv =====
// Package for the radix string to fixed point unit.
// Holds widths, character codes, command/status types and the digit decoder.
// No dependencies.
`default_nettype none
package rsfp_pkg;

  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 15;
  localparam int INT_W           = 32;
  localparam int NUM_W           = 60;
  localparam int DEN_W           = 61;
  localparam int RADIX_W         = 5;
  localparam int FCNT_W          = 4;
  localparam int OUT_W           = 64;
  localparam int REM_W           = DEN_W + 1;
  localparam int QUO_W           = FRAC_BITS + 4;
  localparam int STEP_W          = $clog2(QUO_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef struct packed {
    logic upd;
    logic div_load;
    logic div_step;
    logic finish;
  } rsfp_cmd_t;

  typedef struct packed {
    logic num_zero;
  } rsfp_stat_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_A && c <= CH_F) begin
      t = c - CH_A + 8'd10;
    end
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/radix_string_to_fixed_point_unit.sv =====
// Radix string to unsigned Q32.32 converter, top level; uses rsfp_pkg,
// rsfp_ctrl and rsfp_datapath.
// A non-final character is taken while the input is not stalled. A final
// character stalls the input until its result is in the output register;
// the divider loads and, for a nonzero fraction numerator, runs 36 steps.
// Reset clears all accumulators and control; radix resets to 10.
`default_nettype none
module radix_string_to_fixed_point_unit
  import rsfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OUT_W-1:0]   fixed_value_o,
  output logic               overflow_flag_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_data_i
);

  rsfp_cmd_t  cmd;
  rsfp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rsfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rsfp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .char_code_i     (char_code_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .fixed_value_o   (fixed_value_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule
`default_nettype wire

// ===== sv/rsfp_datapath.sv =====
// Datapath: radix register, integer/fraction accumulators, restoring divider
// and result register. Uses rsfp_pkg; driven by rsfp_ctrl commands.
`default_nettype none
module rsfp_datapath
  import rsfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RADIX_W-1:0]   cfg_data_i,
  input  logic [7:0]           char_code_i,
  input  rsfp_cmd_t            cmd_i,
  output rsfp_stat_t           stat_o,
  output logic [OUT_W-1:0]     fixed_value_o,
  output logic                 overflow_flag_o
);

  logic [RADIX_W-1:0] radix_q;
  logic [INT_W-1:0]   acc_q, acc_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
  logic               sep_q, sep_d;
  logic               sat_q, sat_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]   dvd_q, dvd_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [OUT_W-1:0]   val_q, val_d;
  logic               ovf_q, ovf_d;

  logic [RADIX_W-1:0] ur;
  logic [3:0]         dig;
  logic               is_sep;
  logic [INT_W+4:0]   int_t;
  logic [63:0]        num_t;
  logic [63:0]        den_t;
  logic [REM_W-1:0]   rsh;
  logic [OUT_W:0]     sum;

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      ur = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      ur = RADIX_MAX;
    end else begin
      ur = radix_q;
    end
  end

  assign dig    = digit_of(char_code_i);
  assign is_sep = (char_code_i == CH_DOT) || (char_code_i == CH_COMMA);
  assign int_t  = (37'(acc_q) * 37'(ur)) + 37'(dig);
  assign num_t  = (64'(num_q) * 64'(ur)) + 64'(dig);
  assign den_t  = 64'(den_q) * 64'(ur);
  assign rsh    = {rem_q[REM_W-2:0], dvd_q[QUO_W-1]};
  assign sum    = 65'(64'(acc_q) << FRAC_BITS) + 65'(quo_q);

  always_comb begin
    acc_d  = acc_q;
    num_d  = num_q;
    den_d  = den_q;
    fcnt_d = fcnt_q;
    sep_d  = sep_q;
    sat_d  = sat_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    val_d  = val_q;
    ovf_d  = ovf_q;
    if (cmd_i.upd) begin
      if (!sep_q && is_sep) begin
        sep_d = 1'b1;
      end else if (!sep_q) begin
        if (int_t[INT_W+4:INT_W] != 5'd0) begin
          acc_d = '1;
          sat_d = 1'b1;
        end else begin
          acc_d = int_t[INT_W-1:0];
        end
      end else if (fcnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
        num_d  = num_t[NUM_W-1:0];
        den_d  = den_t[DEN_W-1:0];
        fcnt_d = fcnt_q + FCNT_W'(1);
      end
    end
    if (cmd_i.div_load) begin
      rem_d = REM_W'(num_q >> 4);
      dvd_d = {num_q[3:0], {FRAC_BITS{1'b0}}};
      quo_d = '0;
    end
    if (cmd_i.div_step) begin
      dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
      if (rsh >= REM_W'(den_q)) begin
        rem_d = rsh - REM_W'(den_q);
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rsh;
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      if (sum[OUT_W]) begin
        val_d = '1;
        ovf_d = 1'b1;
      end else begin
        val_d = sum[OUT_W-1:0];
        ovf_d = sat_q;
      end
      acc_d  = '0;
      num_d  = '0;
      den_d  = DEN_W'(1);
      fcnt_d = '0;
      sep_d  = 1'b0;
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      acc_q   <= '0;
      num_q   <= '0;
      den_q   <= DEN_W'(1);
      fcnt_q  <= '0;
      sep_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_data_i;
      end
      acc_q  <= acc_d;
      num_q  <= num_d;
      den_q  <= den_d;
      fcnt_q <= fcnt_d;
      sep_q  <= sep_d;
      sat_q  <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    val_q <= val_d;
    ovf_q <= ovf_d;
  end

  assign stat_o.num_zero = (num_q == '0);
  assign fixed_value_o   = val_q;
  assign overflow_flag_o = ovf_q;

endmodule
`default_nettype wire

// ===== sv/rsfp_ctrl.sv =====
// Controller: character intake, divider sequencing and result handshake.
// Uses rsfp_pkg; commands rsfp_datapath.
`default_nettype none
module rsfp_ctrl
  import rsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_char_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  rsfp_stat_t stat_i,
  output rsfp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   cnt_q;
  logic                out_valid_q;
  logic                accept;
  logic                out_free;

  assign in_stall_o = (state_q != ST_RUN);
  assign accept     = in_valid_i && (state_q == ST_RUN);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.upd      = accept;
    cmd_o.div_load = (state_q == ST_LOAD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (accept && last_char_i) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q <= '0;
          if (stat_i.num_zero) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + STEP_W'(1);
          if (cnt_q == STEP_W'(QUO_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for radix_string_to_fixed_point_unit: drives digit strings with random
// idling and back-pressure and checks each Q32.32 result against a built-in predictor or a table.
// Depends on rsfp_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsfp_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             ovf;
  } conv_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_code_i;
  logic               last_char_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [OUT_W-1:0]   fixed_value_o;
  logic               overflow_flag_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_data_i;

  radix_string_to_fixed_point_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fixed_value_o  (fixed_value_o),
    .overflow_flag_o(overflow_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // converter state mirror
  logic [RADIX_W-1:0] radix_reg;
  logic [INT_W-1:0]   int_acc;
  logic [NUM_W-1:0]   frac_num;
  logic [DEN_W-1:0]   frac_den;
  logic [FCNT_W-1:0]  frac_cnt;
  bit                 sep_seen;
  bit                 int_sat;

  conv_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  chars_sent = 0;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;

  // directed strings
  localparam int NUM_ROWS = 7;
  logic [RADIX_W-1:0] row_radix [NUM_ROWS] = '{5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0, 5'd31};
  string              row_text  [NUM_ROWS] = '{"0", ".", "1,5", "zA", "FFFFFFFFFF.F", ".F",
                                                ".FFFFFFFFFFFFFF,F"};
  bit                 row_typed [NUM_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [OUT_W-1:0]   row_value [NUM_ROWS] = '{64'h0, 64'h0, 64'h0000_0001_8000_0000, 64'h0,
                                                64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                                                64'h0000_0000_FFFF_FFFF};
  bit                 row_ovf   [NUM_ROWS] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  logic [RADIX_W-1:0] phase_radix [6] = '{5'd2, 5'd16, 5'd10, 5'd8, 5'd0, 5'd3};

  function automatic int unsigned eff_radix();
    if (radix_reg < RADIX_MIN) return 2;
    if (radix_reg > RADIX_MAX) return 16;
    return radix_reg;
  endfunction

  function automatic logic [63:0] char_weight(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 64'(c - CH_0);
    if (c >= CH_A && c <= CH_F) return 64'(c - CH_A) + 64'd10;
    return 64'd0;
  endfunction

  task automatic clear_conv();
    int_acc  = '0;
    frac_num = '0;
    frac_den = DEN_W'(1);
    frac_cnt = '0;
    sep_seen = 1'b0;
    int_sat  = 1'b0;
  endtask

  task automatic convert_char(input logic [7:0] c, input bit last, output bit done,
                              output conv_result_t res);
    logic [63:0] r, d, t, n, dv, q, rem, ipart, sum;
    r = 64'(eff_radix());
    d = char_weight(c);
    if (!sep_seen && (c == CH_DOT || c == CH_COMMA)) begin
      sep_seen = 1'b1;
    end else if (!sep_seen) begin
      t = {32'd0, int_acc} * r + d;
      if (t > 64'hFFFF_FFFF) begin
        t = 64'hFFFF_FFFF;
        int_sat = 1'b1;
      end
      int_acc = t[INT_W-1:0];
    end else if (frac_cnt < MAX_FRAC_DIGITS) begin
      t = {4'd0, frac_num} * r + d;
      frac_num = t[NUM_W-1:0];
      t = {3'd0, frac_den} * r;
      frac_den = t[DEN_W-1:0];
      frac_cnt = frac_cnt + 1'b1;
    end
    done = last;
    res  = '0;
    if (last) begin
      n   = {4'd0, frac_num};
      dv  = {3'd0, frac_den};
      q   = n / dv;
      rem = n % dv;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= dv) begin
          rem  = rem - dv;
          q[0] = 1'b1;
        end
      end
      ipart   = {int_acc, 32'd0};
      sum     = ipart + q;
      res.ovf = int_sat;
      if (sum < ipart) begin
        sum     = '1;
        res.ovf = 1'b1;
      end
      res.value = sum;
      clear_conv();
    end
  endtask

  task automatic push_char(input logic [7:0] c, input bit last, input bit typed,
                           input conv_result_t typed_res);
    bit           done;
    conv_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    convert_char(c, last, done, res);
    if (done) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_reg = v;
  endtask

  function automatic logic [7:0] random_digit(input int unsigned base);
    int unsigned v;
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 8'($urandom_range(0, 255));
    if (sel < 3) v = $urandom_range(0, 15);
    else v = $urandom_range(0, base - 1);
    return (v < 10) ? CH_0 + 8'(v) : CH_A + 8'(v - 10);
  endfunction

  task automatic send_random_string();
    logic [7:0]  chars[$];
    int unsigned int_len;
    int unsigned frac_len;
    int unsigned base;
    base = eff_radix();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      int_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 36) : $urandom_range(0, 8);
      repeat (int_len) chars.push_back(random_digit(base));
      if ($urandom_range(0, 3) != 0) begin
        chars.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        frac_len = $urandom_range(0, 18);
        repeat (frac_len) chars.push_back(random_digit(base));
      end
      if (chars.size() == 0) chars.push_back(random_digit(base));
    end
    foreach (chars[i]) push_char(chars[i], i == chars.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin : result_check
    conv_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: fixed_value %h overflow_flag %b",
               fixed_value_o, overflow_flag_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (fixed_value_o !== want.value) begin
          $error("fixed_value expected %h actual %h", want.value, fixed_value_o);
          mismatch_count++;
        end
        if (overflow_flag_o !== want.ovf) begin
          $error("overflow_flag expected %b actual %b", want.ovf, overflow_flag_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output back-pressure
  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i <= 1'b1;
        stall_left  = 300;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(1, 4);
      end
    end
  end

  initial begin : stimulus
    int unsigned  start;
    conv_result_t typed_res;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    radix_reg   = RADIX_RESET;
    clear_conv();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < NUM_ROWS; row++) begin
      if (row_radix[row] != radix_reg) begin
        settle(50);
        write_radix(row_radix[row]);
      end
      typed_res = '{value: row_value[row], ovf: row_ovf[row]};
      for (int j = 0; j < row_text[row].len(); j++) begin
        push_char(row_text[row].getc(j), j == row_text[row].len() - 1, row_typed[row],
                  typed_res);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle(50);
      write_radix(p == 4 ? RADIX_W'($urandom_range(0, 31)) : phase_radix[p]);
      idle_on = (p != 5);
      if (p == 1) hold_req = 1'b1;
      start = chars_sent;
      while (chars_sent - start < 65) begin
        send_random_string();
        if (p != 1 && p != 5 && $urandom_range(0, 9) == 0) settle(0);
      end
    end

    settle(50);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
